[rtl/core/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned LimitSlack   = 64;
  localparam int unsigned MergeSlack   = 64;
  localparam int unsigned RstHeapBytes = 65536;
  localparam int unsigned RstMinBlock  = 128;
  localparam int unsigned RstInitBlock = 512;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_BAD_ALIGN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_HEAP_BYTES    = 2'd0,
    CFG_BASE_LOW_BITS = 2'd1,
    CFG_MIN_BLOCK     = 2'd2,
    CFG_INITIAL_BLOCK = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_size;
    logic [6:0]  alignment;
    logic [15:0] address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_offset;
    logic        is_allocated;
  } res_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_SWEEP,
    DP_SWEEP_CLR,
    DP_INIT_DONE,
    DP_SET_LREQ,
    DP_WALK_START,
    DP_READ_P,
    DP_EVAL,
    DP_TAKE_SPLIT,
    DP_TAKE_TAIL,
    DP_TAKE_WHOLE,
    DP_ADV_P,
    DP_CAPT_P,
    DP_READ_NP,
    DP_CAPT_N,
    DP_MERGE_KILL,
    DP_MERGE_GROW,
    DP_SKIP2,
    DP_SCAN_READ,
    DP_SCAN_HIT,
    DP_SCAN_NEXT,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    set_status;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic over_limit;
    logic over_largest;
    logic align_bad;
    logic p_at_end;
    logic fit;
    logic split;
    logic cand;
    logic np_at_end;
    logic n_free;
    logic scan_hit;
    logic scan_last;
  } dp_sts_t;

endpackage

[rtl/core/ffha_ram.sv]
// Generic simple dual-port RAM with registered read.
module ffha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/ffha_ctrl.sv]
// Controller state machine of the heap allocator.
module ffha_ctrl import ffha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] opcode_i,
  input  dp_sts_t    sts_i,
  output logic       busy_o,
  output dp_cmd_t    dp_cmd_o
);

  typedef enum logic [20:0] {
    S_RST_CLR   = 21'h000001,
    S_IDLE      = 21'h000002,
    S_I_SWEEP   = 21'h000004,
    S_I_DONE    = 21'h000008,
    S_A_CHK     = 21'h000010,
    S_A_POST    = 21'h000020,
    S_A_ALIGN   = 21'h000040,
    S_A_WALK    = 21'h000080,
    S_A_EVAL    = 21'h000100,
    S_A_DEC     = 21'h000200,
    S_A_TAIL    = 21'h000400,
    S_A_RESTART = 21'h000800,
    S_C_LOOP    = 21'h001000,
    S_C_CAP     = 21'h002000,
    S_C_DEC     = 21'h004000,
    S_C_CAPN    = 21'h008000,
    S_C_DEC2    = 21'h010000,
    S_C_GROW    = 21'h020000,
    S_S_RD      = 21'h040000,
    S_S_CHK     = 21'h080000,
    S_RESP      = 21'h100000
  } state_e;

  state_e state_q, state_d;
  logic   ret_walk_q, ret_walk_d;
  logic   coll_q, coll_d;
  state_e ret_state;

  assign ret_state = ret_walk_q ? S_A_RESTART : S_A_POST;
  assign busy_o    = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    ret_walk_d = ret_walk_q;
    coll_d     = coll_q;
    dp_cmd_o   = '{op: DP_NOP, set_status: 1'b0, code: ST_OK};
    case (state_q)
      S_RST_CLR: begin
        dp_cmd_o.op = DP_SWEEP_CLR;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          dp_cmd_o.op = DP_LATCH;
          case (opcode_e'(opcode_i))
            OP_INIT:  state_d = S_I_SWEEP;
            OP_ALLOC: state_d = S_A_CHK;
            default:  state_d = S_S_RD;
          endcase
        end
      end
      S_I_SWEEP: begin
        dp_cmd_o.op = DP_SWEEP;
        if (sts_i.sweep_last) state_d = S_I_DONE;
      end
      S_I_DONE: begin
        dp_cmd_o.op = DP_INIT_DONE;
        state_d     = S_RESP;
      end
      S_A_CHK: begin
        if (sts_i.over_limit) begin
          dp_cmd_o.set_status = 1'b1;
          dp_cmd_o.code       = ST_TOO_LARGE;
          state_d             = S_RESP;
        end else if (sts_i.over_largest) begin
          dp_cmd_o.op = DP_SET_LREQ;
          ret_walk_d  = 1'b0;
          state_d     = S_C_LOOP;
        end else begin
          state_d = S_A_ALIGN;
        end
      end
      S_A_POST: begin
        if (sts_i.over_largest) begin
          dp_cmd_o.set_status = 1'b1;
          dp_cmd_o.code       = ST_NO_FIT;
          state_d             = S_RESP;
        end else begin
          state_d = S_A_ALIGN;
        end
      end
      S_A_ALIGN: begin
        if (sts_i.align_bad) begin
          dp_cmd_o.set_status = 1'b1;
          dp_cmd_o.code       = ST_BAD_ALIGN;
          state_d             = S_RESP;
        end else begin
          dp_cmd_o.op = DP_WALK_START;
          coll_d      = 1'b0;
          state_d     = S_A_WALK;
        end
      end
      S_A_WALK: begin
        if (sts_i.p_at_end) begin
          if (coll_q) begin
            dp_cmd_o.set_status = 1'b1;
            dp_cmd_o.code       = ST_NO_FIT;
            state_d             = S_RESP;
          end else begin
            dp_cmd_o.op = DP_SET_LREQ;
            coll_d      = 1'b1;
            ret_walk_d  = 1'b1;
            state_d     = S_C_LOOP;
          end
        end else begin
          dp_cmd_o.op = DP_READ_P;
          state_d     = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        dp_cmd_o.op = DP_EVAL;
        state_d     = S_A_DEC;
      end
      S_A_DEC: begin
        if (sts_i.fit) begin
          if (sts_i.split) begin
            dp_cmd_o.op = DP_TAKE_SPLIT;
            state_d     = S_A_TAIL;
          end else begin
            dp_cmd_o.op = DP_TAKE_WHOLE;
            state_d     = S_RESP;
          end
        end else begin
          dp_cmd_o.op = DP_ADV_P;
          state_d     = S_A_WALK;
        end
      end
      S_A_TAIL: begin
        dp_cmd_o.op = DP_TAKE_TAIL;
        state_d     = S_RESP;
      end
      S_A_RESTART: begin
        dp_cmd_o.op = DP_WALK_START;
        state_d     = S_A_WALK;
      end
      S_C_LOOP: begin
        if (sts_i.p_at_end) begin
          state_d = ret_state;
        end else begin
          dp_cmd_o.op = DP_READ_P;
          state_d     = S_C_CAP;
        end
      end
      S_C_CAP: begin
        dp_cmd_o.op = DP_CAPT_P;
        state_d     = S_C_DEC;
      end
      S_C_DEC: begin
        if (sts_i.cand) begin
          if (sts_i.np_at_end) begin
            state_d = ret_state;
          end else begin
            dp_cmd_o.op = DP_READ_NP;
            state_d     = S_C_CAPN;
          end
        end else begin
          dp_cmd_o.op = DP_ADV_P;
          state_d     = S_C_LOOP;
        end
      end
      S_C_CAPN: begin
        dp_cmd_o.op = DP_CAPT_N;
        state_d     = S_C_DEC2;
      end
      S_C_DEC2: begin
        if (sts_i.n_free) begin
          dp_cmd_o.op = DP_MERGE_KILL;
          state_d     = S_C_GROW;
        end else begin
          dp_cmd_o.op = DP_SKIP2;
          state_d     = S_C_LOOP;
        end
      end
      S_C_GROW: begin
        // stay on the same block: it may absorb the next one too
        dp_cmd_o.op = DP_MERGE_GROW;
        state_d     = S_C_LOOP;
      end
      S_S_RD: begin
        dp_cmd_o.op = DP_SCAN_READ;
        state_d     = S_S_CHK;
      end
      S_S_CHK: begin
        if (sts_i.scan_hit) begin
          dp_cmd_o.op = DP_SCAN_HIT;
          state_d     = S_RESP;
        end else if (sts_i.scan_last) begin
          state_d = S_RESP;
        end else begin
          dp_cmd_o.op = DP_SCAN_NEXT;
          state_d     = S_S_RD;
        end
      end
      S_RESP: begin
        dp_cmd_o.op = DP_RESULT;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_RST_CLR;
      ret_walk_q <= 1'b0;
      coll_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_walk_q <= ret_walk_d;
      coll_q     <= coll_d;
    end
  end

endmodule

[rtl/core/ffha_dp.sv]
// Datapath of the heap allocator: registers, block store and arithmetic.
module ffha_dp import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 65536,
  parameter int unsigned DESC_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  cmd_t        cmd_i,
  input  dp_cmd_t     dp_cmd_i,
  output dp_sts_t     sts_o,
  output res_t        res_o,
  output logic        res_valid_o
);

  localparam int unsigned AW       = $clog2(HEAP_BYTES);
  localparam int unsigned PW       = ((AW > 17) ? AW : 17) + 2;
  localparam int unsigned ScanBack = 63 + DESC_BYTES;
  localparam int unsigned KW       = $clog2(ScanBack + 1);
  localparam int unsigned WW       = PW + 2;

  typedef struct packed {
    logic          valid;
    logic          free;
    logic [PW-1:0] size;
  } word_t;

  // configuration
  logic [16:0] heap_bytes_q;
  logic [5:0]  base_q;
  logic [12:0] min_q;
  logic [16:0] init_q;

  // control state
  logic [PW-1:0] largest_q, lreq_q, heap_end_q;
  logic [AW-1:0] s_q;
  logic          res_valid_q;

  // working registers
  cmd_t          cmd_q;
  logic [PW-1:0] p_q, np_q, at_q, sz_q, szn_q, used_q;
  logic [6:0]    shift_q;
  logic          fit_q, cand_q, frn_q;
  logic [15:0]   a_q;
  logic [KW-1:0] k_q;
  status_e       status_q;
  logic [15:0]   pay_q;
  logic          alloc_q;

  word_t         rd, wdata;
  logic [WW-1:0] rdata_raw;
  logic          we;
  logic [AW-1:0] waddr, raddr;

  logic [PW-1:0] total_w, limit_w, size_w, start_w, need_w, used_w, stride_w;
  logic [PW-1:0] grow_w, min_w;
  logic [6:0]    amask_w, shift_w;
  logic          fit_w, layout_hit, sweep_last, a_in_range;

  assign rd = word_t'(rdata_raw);

  assign total_w = (PW'(heap_bytes_q) > PW'(HEAP_BYTES)) ? PW'(HEAP_BYTES)
                                                          : PW'(heap_bytes_q);
  assign limit_w = (total_w > PW'(LimitSlack + DESC_BYTES))
                   ? total_w - PW'(LimitSlack + DESC_BYTES) : '0;
  assign size_w  = PW'(cmd_q.request_size);
  assign min_w   = PW'(min_q);

  // alignment shift of the payload behind the header at p
  assign start_w = PW'(base_q) + p_q + PW'(DESC_BYTES);
  assign amask_w = cmd_q.alignment - 7'd1;
  assign shift_w = (7'd0 - start_w[6:0]) & amask_w;
  assign need_w  = PW'(shift_w) + size_w;
  assign fit_w   = rd.free && (rd.size >= need_w);
  assign used_w  = (need_w <= min_w) ? min_w : need_w;

  assign stride_w   = PW'(init_q) + PW'(DESC_BYTES);
  assign layout_hit = (PW'(s_q) == at_q) && ((at_q + stride_w) <= total_w);
  assign sweep_last = (s_q == AW'(HEAP_BYTES - 1));
  assign grow_w     = sz_q + szn_q + PW'(DESC_BYTES);
  assign a_in_range = (PW'(a_q) < PW'(HEAP_BYTES));

  always_comb begin
    sts_o.sweep_last   = sweep_last;
    sts_o.over_limit   = size_w > limit_w;
    sts_o.over_largest = size_w > largest_q;
    sts_o.align_bad    = !(cmd_q.alignment == 7'd4 || cmd_q.alignment == 7'd8 ||
                           cmd_q.alignment == 7'd16 || cmd_q.alignment == 7'd32 ||
                           cmd_q.alignment == 7'd64);
    sts_o.p_at_end     = p_q >= heap_end_q;
    sts_o.fit          = fit_q;
    sts_o.split        = sz_q >= (used_q + PW'(DESC_BYTES) + min_w);
    sts_o.cand         = cand_q;
    sts_o.np_at_end    = np_q >= heap_end_q;
    sts_o.n_free       = frn_q;
    sts_o.scan_hit     = rd.valid && a_in_range;
    sts_o.scan_last    = (k_q == KW'(ScanBack)) || (a_q == 16'd0);
  end

  // store port selection
  always_comb begin
    we    = 1'b0;
    waddr = p_q[AW-1:0];
    wdata = '0;
    raddr = p_q[AW-1:0];
    case (dp_cmd_i.op)
      DP_SWEEP: begin
        we    = 1'b1;
        waddr = s_q;
        if (layout_hit) wdata = '{valid: 1'b1, free: 1'b1, size: PW'(init_q)};
      end
      DP_SWEEP_CLR: begin
        we    = 1'b1;
        waddr = s_q;
      end
      DP_TAKE_SPLIT: begin
        we    = 1'b1;
        wdata = '{valid: 1'b1, free: 1'b0, size: used_q};
      end
      DP_TAKE_TAIL: begin
        we    = 1'b1;
        waddr = AW'(p_q + PW'(DESC_BYTES) + used_q);
        wdata = '{valid: 1'b1, free: 1'b1, size: sz_q - used_q - PW'(DESC_BYTES)};
      end
      DP_TAKE_WHOLE: begin
        we    = 1'b1;
        wdata = '{valid: 1'b1, free: 1'b0, size: sz_q};
      end
      DP_MERGE_KILL: begin
        we    = 1'b1;
        waddr = np_q[AW-1:0];
      end
      DP_MERGE_GROW: begin
        we    = 1'b1;
        wdata = '{valid: 1'b1, free: 1'b1, size: grow_w};
      end
      DP_SCAN_HIT: begin
        we    = (opcode_e'(cmd_q.opcode) == OP_FREE);
        waddr = AW'(a_q);
        wdata = '{valid: 1'b1, free: 1'b1, size: rd.size};
      end
      DP_READ_NP:   raddr = np_q[AW-1:0];
      DP_SCAN_READ: raddr = AW'(a_q);
      default: ;
    endcase
  end

  ffha_ram #(
    .Width (WW),
    .Depth (HEAP_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_bytes_q <= 17'(RstHeapBytes);
      base_q       <= '0;
      min_q        <= 13'(RstMinBlock);
      init_q       <= 17'(RstInitBlock);
      largest_q    <= PW'(RstInitBlock);
      lreq_q       <= PW'(RstInitBlock);
      heap_end_q   <= '0;
      s_q          <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= (dp_cmd_i.op == DP_RESULT);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HEAP_BYTES:    heap_bytes_q <= cfg_data_i;
          CFG_BASE_LOW_BITS: base_q       <= cfg_data_i[5:0];
          CFG_MIN_BLOCK:     min_q        <= cfg_data_i[12:0];
          CFG_INITIAL_BLOCK: init_q       <= cfg_data_i;
          default: ;
        endcase
      end
      case (dp_cmd_i.op)
        DP_SWEEP, DP_SWEEP_CLR: s_q <= sweep_last ? '0 : s_q + AW'(1);
        DP_INIT_DONE: begin
          heap_end_q <= at_q;
          largest_q  <= PW'(init_q);
          lreq_q     <= PW'(init_q);
        end
        DP_SET_LREQ: lreq_q <= size_w;
        DP_MERGE_GROW: if (grow_w > largest_q) largest_q <= grow_w;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.set_status) status_q <= dp_cmd_i.code;
    case (dp_cmd_i.op)
      DP_LATCH: begin
        cmd_q    <= cmd_i;
        a_q      <= cmd_i.address;
        k_q      <= '0;
        at_q     <= '0;
        status_q <= ST_OK;
        pay_q    <= '0;
        alloc_q  <= 1'b0;
      end
      DP_SWEEP: if (layout_hit) at_q <= at_q + stride_w;
      DP_SET_LREQ, DP_WALK_START: p_q <= '0;
      DP_EVAL: begin
        sz_q    <= rd.size;
        shift_q <= shift_w;
        used_q  <= used_w;
        fit_q   <= fit_w;
      end
      DP_TAKE_SPLIT, DP_TAKE_WHOLE:
        pay_q <= 16'(p_q + PW'(DESC_BYTES) + PW'(shift_q));
      DP_ADV_P: p_q <= p_q + PW'(DESC_BYTES) + sz_q;
      DP_CAPT_P: begin
        sz_q   <= rd.size;
        np_q   <= p_q + PW'(DESC_BYTES) + rd.size;
        cand_q <= rd.free && (rd.size <= lreq_q + PW'(MergeSlack));
      end
      DP_CAPT_N: begin
        szn_q <= rd.size;
        frn_q <= rd.free;
      end
      DP_SKIP2: p_q <= np_q + PW'(DESC_BYTES) + szn_q;
      DP_SCAN_HIT:
        if (opcode_e'(cmd_q.opcode) == OP_QUERY) alloc_q <= !rd.free;
      DP_SCAN_NEXT: begin
        a_q <= a_q - 16'd1;
        k_q <= k_q + KW'(1);
      end
      default: ;
    endcase
  end

  assign res_o       = '{status: status_q, payload_offset: pay_q, is_allocated: alloc_q};
  assign res_valid_o = res_valid_q;

endmodule

[rtl/core/first_fit_heap_allocator_top.sv]
// Top level of the first-fit heap allocator with split and coalesce.
//
//  port group                   dir  handshake           beat
//  start_i / busy_o / cmd_i     in   start & !busy       one command
//  res_valid_o / res_o          out  one-cycle strobe    one result
//  cfg_valid_i / cfg_ready_o    in   valid & ready       one register write
//
// Init sweeps the whole block store.
// Alloc visits the blocks one at a time, both in a walk and in a coalesce pass;
// the block store's single read port sets the pace of each visit.
// Free and query scan back one offset at a time, over at most 64 + DESC_BYTES offsets.
// After reset a clearing pass over the block store runs with busy_o high.
// Results cannot be stalled; one command is in flight at a time.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 65536,
  parameter int unsigned DESC_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  ffha_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (cmd_i.opcode),
    .sts_i    (dp_sts),
    .busy_o   (busy_o),
    .dp_cmd_o (dp_cmd)
  );

  ffha_dp #(
    .HEAP_BYTES (HEAP_BYTES),
    .DESC_BYTES (DESC_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_i),
    .dp_cmd_i    (dp_cmd),
    .sts_o       (dp_sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

[sim/first_fit_heap_allocator_top_tb.sv]
// Self-checking testbench for the first-fit heap allocator: directed table, then random phases.
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_tb;
  import ffha_pkg::*;

  localparam int unsigned HeapMax   = 65536;
  localparam int unsigned HdrBytes  = 8;
  localparam int unsigned ScanBack  = 63 + HdrBytes;
  localparam int unsigned IdleLimit = 2000000;

  typedef struct {
    cmd_t cmd;
    bit   typed;
    res_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  cmd_t        cmd_i;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [16:0] cfg_data_i;

  first_fit_heap_allocator_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow heap
  bit          hdr_mark [HeapMax];
  int unsigned blk_len  [HeapMax];
  bit          blk_open [HeapMax];
  int unsigned max_blk, max_req, end_off;
  int unsigned r_heap, r_base, r_minblk, r_initblk;

  res_t        pending_responses[$];
  int unsigned live_payloads[$];
  int unsigned err_count;
  int unsigned idle_cycles;
  bit          no_idle;

  task automatic report(string what, res_t got, res_t want);
    $display("MISMATCH %s: got st=%0d off=%0d alloc=%0d, want st=%0d off=%0d alloc=%0d",
             what, got.status, got.payload_offset, got.is_allocated,
             want.status, want.payload_offset, want.is_allocated);
    err_count++;
  endtask

  function automatic int unsigned usable_bytes();
    return (r_heap > HeapMax) ? HeapMax : r_heap;
  endfunction

  function automatic void heap_layout();
    int unsigned stride, count, at;
    stride = r_initblk + HdrBytes;
    count  = usable_bytes() / stride;
    at     = 0;
    foreach (hdr_mark[i]) hdr_mark[i] = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      hdr_mark[at] = 1'b1;
      blk_len[at]  = r_initblk;
      blk_open[at] = 1'b1;
      at += stride;
    end
    end_off = at;
    max_blk = r_initblk;
    max_req = r_initblk;
  endfunction

  function automatic void merge_free_runs();
    int unsigned p, np;
    p = 0;
    while (p < end_off) begin
      if (blk_open[p] && blk_len[p] <= max_req + MergeSlack) begin
        np = p + HdrBytes + blk_len[p];
        if (np >= end_off) return;
        if (blk_open[np]) begin
          hdr_mark[np] = 1'b0;
          blk_len[p]   = blk_len[p] + blk_len[np] + HdrBytes;
          if (blk_len[p] > max_blk) max_blk = blk_len[p];
        end else begin
          p = np + HdrBytes + blk_len[np];
        end
      end else begin
        p = p + HdrBytes + blk_len[p];
      end
    end
  endfunction

  function automatic status_e place_request(int unsigned sz, int unsigned al,
                                            output int unsigned off);
    int unsigned total, lim, p, bsz, first, shift, used, np;
    bit merged;
    total  = usable_bytes();
    lim    = (total > LimitSlack + HdrBytes) ? total - LimitSlack - HdrBytes : 0;
    p      = 0;
    merged = 1'b0;
    off    = 0;
    if (sz > lim) return ST_TOO_LARGE;
    if (sz > max_blk) begin
      max_req = sz;
      merge_free_runs();
      if (sz > max_blk) return ST_NO_FIT;
    end
    if (!(al == 4 || al == 8 || al == 16 || al == 32 || al == 64)) return ST_BAD_ALIGN;
    forever begin
      if (p >= end_off) begin
        if (merged) return ST_NO_FIT;
        merged  = 1'b1;
        max_req = sz;
        merge_free_runs();
        p = 0;
        if (p >= end_off) return ST_NO_FIT;
      end
      bsz = blk_len[p];
      if (blk_open[p]) begin
        first = r_base + p + HdrBytes;
        shift = (al - (first & (al - 1))) & (al - 1);
        if (bsz >= shift + sz) begin
          used = (shift + sz <= r_minblk) ? r_minblk : shift + sz;
          if (longint'(bsz) - longint'(used) - longint'(HdrBytes) >= longint'(r_minblk)) begin
            np           = p + HdrBytes + used;
            blk_len[p]   = used;
            hdr_mark[np] = 1'b1;
            blk_len[np]  = bsz - used - HdrBytes;
            blk_open[np] = 1'b1;
          end
          blk_open[p] = 1'b0;
          off = (p + HdrBytes + shift) & 16'hFFFF;
          return ST_OK;
        end
      end
      p = p + HdrBytes + bsz;
    end
  endfunction

  function automatic bit locate_header(int unsigned addr, output int unsigned hdr);
    hdr = 0;
    for (int unsigned k = 0; k <= ScanBack && k <= addr; k++) begin
      if (hdr_mark[addr - k]) begin
        hdr = addr - k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t compute_response(cmd_t c);
    res_t r;
    int unsigned off, hdr;
    r = '0;
    case (opcode_e'(c.opcode))
      OP_INIT: heap_layout();
      OP_ALLOC: begin
        r.status = place_request(c.request_size, c.alignment, off);
        if (r.status == ST_OK) begin
          r.payload_offset = 16'(off);
          live_payloads.push_back(off);
        end
      end
      OP_FREE: if (locate_header(c.address, hdr)) blk_open[hdr] = 1'b1;
      default: if (locate_header(c.address, hdr)) r.is_allocated = !blk_open[hdr];
    endcase
    return r;
  endfunction

  function automatic row_t mk(opcode_e op, int unsigned sz, int unsigned al, int unsigned ad,
                              bit typed = 0, status_e st = ST_OK, int unsigned off = 0);
    row_t r;
    r.cmd   = '{opcode: op, request_size: 16'(sz), alignment: 7'(al), address: 16'(ad)};
    r.typed = typed;
    r.want  = '{status: st, payload_offset: 16'(off), is_allocated: 1'b0};
    return r;
  endfunction

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (res_valid_o) begin
        if (pending_responses.size() == 0) begin
          report("unexpected result", res_o, '0);
        end else begin
          res_t want;
          want = pending_responses.pop_front();
          if (res_o.status != want.status) report("status", res_o, want);
          if (res_o.payload_offset != want.payload_offset) report("payload_offset", res_o, want);
          if (res_o.is_allocated != want.is_allocated) report("is_allocated", res_o, want);
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic idle_gap();
    int unsigned n, pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 50) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
  endtask

  task automatic send_cmd(cmd_t c, bit typed = 0, res_t want = '0);
    res_t pred;
    idle_gap();
    @(negedge clk_i);
    start_i = 1'b1;
    cmd_i   = c;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    pred = compute_response(c);
    pending_responses.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = 17'(val);
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      CFG_HEAP_BYTES:    r_heap    = val & 17'h1FFFF;
      CFG_BASE_LOW_BITS: r_base    = val & 6'h3F;
      CFG_MIN_BLOCK:     r_minblk  = val & 13'h1FFF;
      default:           r_initblk = val & 17'h1FFFF;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick, ad;
    pick = $urandom_range(0, 99);
    c = '0;
    if (pick < 55) begin
      c.opcode = OP_ALLOC;
      if ($urandom_range(0, 9) == 0) c.request_size = 16'($urandom_range(0, 65535));
      else c.request_size = 16'($urandom_range(0, (r_initblk > 32767) ? 65535 : 2 * r_initblk));
      if ($urandom_range(0, 9) < 8) c.alignment = 7'(4 << $urandom_range(0, 4));
      else c.alignment = 7'($urandom_range(0, 127));
      c.address = 16'($urandom_range(0, 65535));
    end else begin
      c.opcode = (pick < 80) ? OP_FREE : OP_QUERY;
      if (live_payloads.size() != 0 && $urandom_range(0, 3) != 0) begin
        ad = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
        ad = ad + $urandom_range(0, 80);
        c.address = 16'((ad > 65535) ? 65535 : ad);
      end else begin
        c.address = 16'($urandom_range(0, 65535));
      end
      c.request_size = 16'($urandom_range(0, 65535));
      c.alignment    = 7'($urandom_range(0, 127));
    end
    return c;
  endfunction

  initial begin
    row_t        plan[$];
    int unsigned phases[$][4];
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_HEAP_BYTES;
    cfg_data_i  = '0;
    err_count   = 0;
    idle_cycles = 0;
    no_idle     = 0;
    r_heap      = RstHeapBytes;
    r_base      = 0;
    r_minblk    = RstMinBlock;
    r_initblk   = RstInitBlock;
    max_blk     = 512;
    max_req     = 512;
    end_off     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty heap before init, limits, alignment errors, split and scans
    plan.push_back(mk(OP_ALLOC, 16, 8, 0, 1, ST_NO_FIT));
    plan.push_back(mk(OP_QUERY, 0, 0, 0, 1, ST_OK));
    plan.push_back(mk(OP_FREE, 0, 0, 65535, 1, ST_OK));
    plan.push_back(mk(OP_ALLOC, 65535, 127, 0, 1, ST_TOO_LARGE));
    plan.push_back(mk(OP_ALLOC, 65465, 4, 0, 1, ST_TOO_LARGE));
    plan.push_back(mk(OP_INIT, 0, 0, 0, 1, ST_OK));
    plan.push_back(mk(OP_ALLOC, 0, 4, 0, 1, ST_OK, 8));
    plan.push_back(mk(OP_QUERY, 0, 0, 8));
    plan.push_back(mk(OP_QUERY, 0, 0, 70));
    plan.push_back(mk(OP_ALLOC, 10, 127, 0, 1, ST_BAD_ALIGN));
    plan.push_back(mk(OP_ALLOC, 10, 0, 0, 1, ST_BAD_ALIGN));
    plan.push_back(mk(OP_ALLOC, 10, 3, 0, 1, ST_BAD_ALIGN));
    plan.push_back(mk(OP_ALLOC, 100, 64, 0));
    plan.push_back(mk(OP_ALLOC, 300, 32, 0));
    plan.push_back(mk(OP_ALLOC, 500, 16, 0));
    plan.push_back(mk(OP_ALLOC, 600, 8, 0));
    plan.push_back(mk(OP_ALLOC, 2000, 100, 0));
    plan.push_back(mk(OP_FREE, 0, 0, 8));
    plan.push_back(mk(OP_QUERY, 0, 0, 8));
    plan.push_back(mk(OP_FREE, 0, 0, 600));
    plan.push_back(mk(OP_QUERY, 0, 0, 65535));
    plan.push_back(mk(OP_ALLOC, 65464, 4, 0));
    plan.push_back(mk(OP_ALLOC, 40000, 64, 0));
    plan.push_back(mk(OP_QUERY, 0, 0, 40000));
    foreach (plan[i]) send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
    drain();

    phases.push_back('{1024, 63, 1, 1});
    phases.push_back('{65536, 0, 4096, 65536});
    phases.push_back('{4096, 21, 64, 100});
    phases.push_back('{32768, 42, 16, 2000});
    phases.push_back('{2048, 7, 200, 56});
    phases.push_back('{$urandom_range(1024, 65536), $urandom_range(0, 63),
                      $urandom_range(1, 4096), $urandom_range(1, 4000)});
    phases.push_back('{$urandom_range(1024, 8192), $urandom_range(0, 63),
                      $urandom_range(1, 512), $urandom_range(1, 600)});
    phases.push_back('{65536, 13, 128, 512});

    foreach (phases[ph]) begin
      write_reg(CFG_HEAP_BYTES, phases[ph][0]);
      write_reg(CFG_BASE_LOW_BITS, phases[ph][1]);
      write_reg(CFG_MIN_BLOCK, phases[ph][2]);
      write_reg(CFG_INITIAL_BLOCK, phases[ph][3]);
      live_payloads.delete();
      no_idle = (ph % 3 == 1);
      send_cmd('{opcode: OP_INIT, request_size: '0, alignment: '0, address: '0});
      repeat (48) send_cmd(random_cmd());
      // hold off until every pending result is back
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
